/* sv/edge_pair_hash_table_macros.svh */
// assertion helpers used by the file that checks this block
`ifndef EDGE_PAIR_HASH_TABLE_MACROS_SVH
`define EDGE_PAIR_HASH_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define EPHT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define EPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/epht_pkg.sv */
package epht_pkg;

    // default sizes
    localparam int TABLE_SLOTS_DEF = 4096;
    localparam int MAX_EDGES_DEF   = 2048;

    // fixed field widths
    localparam int VERTEX_W     = 32;
    localparam int KEY_W        = 2 * VERTEX_W;
    localparam int EDGE_ID_W    = 11;
    localparam int EDGE_TOTAL_W = 12;
    localparam int LOG2_W       = 4;

    // table size register
    localparam logic [LOG2_W-1:0] TABLE_LOG2_RESET = 4'd12;
    localparam logic [LOG2_W-1:0] TABLE_LOG2_MIN   = 4'd4;
    localparam int                TABLE_LOG2_CAP   = 15;

    // hash finalizer constants
    localparam logic [KEY_W-1:0] HASH_MUL1  = 64'hff51_afd7_ed55_8ccd;
    localparam logic [KEY_W-1:0] HASH_MUL2  = 64'hc4ce_b9fe_1a85_ec53;
    localparam int               HASH_SHIFT = 33;

    typedef enum logic [1:0] {
        CMD_INTERN = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_FOUND = 2'd0,
        STATUS_NEW   = 2'd1,
        STATUS_MISS  = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                  command;
        logic [VERTEX_W-1:0]   vertex_a;
        logic [VERTEX_W-1:0]   vertex_b;
        logic [EDGE_ID_W-1:0]  edge_index;
    } epht_req_t;

    typedef struct packed {
        status_t                 status;
        logic [EDGE_ID_W-1:0]    edge_id;
        logic [VERTEX_W-1:0]     edge_low;
        logic [VERTEX_W-1:0]     edge_high;
        logic [EDGE_TOTAL_W-1:0] edge_total;
    } epht_rsp_t;

    // one xor-shift round of the finalizer
    function automatic logic [KEY_W-1:0] xor_shift(input logic [KEY_W-1:0] k);
        return k ^ (k >> HASH_SHIFT);
    endfunction

endpackage

/* sv/epht_mul64.sv */
module epht_mul64
    import epht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] a,
    input  logic [KEY_W-1:0] b,
    output logic             done,
    output logic [KEY_W-1:0] product
);

    localparam int HALF_W = KEY_W / 2;

    // step codes of the partial-product sequence
    localparam logic [1:0] STEP_LL  = 2'd0;
    localparam logic [1:0] STEP_HL  = 2'd1;
    localparam logic [1:0] STEP_LH  = 2'd2;
    localparam logic [1:0] STEP_ACC = 2'd3;

    logic [KEY_W-1:0]  a_reg;
    logic [KEY_W-1:0]  b_reg;
    logic [KEY_W-1:0]  prod_reg;
    logic [KEY_W-1:0]  acc_reg;
    logic [1:0]        step_reg;
    logic              run_reg;
    logic              done_reg;
    logic [HALF_W-1:0] op_x;
    logic [HALF_W-1:0] op_y;
    logic [KEY_W-1:0]  mul_out;

    // shared half-width multiplier, operand halves picked by step
    always_comb
    begin
        op_x    = (step_reg == STEP_HL) ? a_reg[KEY_W-1:HALF_W] : a_reg[HALF_W-1:0];
        op_y    = (step_reg == STEP_LH) ? b_reg[KEY_W-1:HALF_W] : b_reg[HALF_W-1:0];
        mul_out = KEY_W'(op_x) * KEY_W'(op_y);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= STEP_LL;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_LL;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == STEP_ACC)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // product register and low-64 accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (run_reg)
        begin
            prod_reg <= mul_out;
            case (step_reg) inside
                STEP_HL:
                begin
                    acc_reg <= prod_reg;
                end
                STEP_LH, STEP_ACC:
                begin
                    acc_reg[KEY_W-1:HALF_W] <= acc_reg[KEY_W-1:HALF_W]
                                               + prod_reg[HALF_W-1:0];
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* sv/epht_edge_store.sv */
module epht_edge_store
    import epht_pkg::*;
#(
    parameter int DEPTH = MAX_EDGES_DEF,
    parameter int AW    = $clog2(MAX_EDGES_DEF)
)
(
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [VERTEX_W-1:0] wr_low,
    input  logic [VERTEX_W-1:0] wr_high,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output logic [VERTEX_W-1:0] rd_low,
    output logic [VERTEX_W-1:0] rd_high
);

    logic [VERTEX_W-1:0] low_mem  [DEPTH];
    logic [VERTEX_W-1:0] high_mem [DEPTH];
    logic [VERTEX_W-1:0] rd_low_reg;
    logic [VERTEX_W-1:0] rd_high_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            low_mem[waddr]  <= wr_low;
            high_mem[waddr] <= wr_high;
        end
        if (re)
        begin
            rd_low_reg  <= low_mem[raddr];
            rd_high_reg <= high_mem[raddr];
        end
    end

    assign rd_low  = rd_low_reg;
    assign rd_high = rd_high_reg;

endmodule

/* sv/edge_pair_hash_table.sv */
// Edge pair hash table: hands out dense edge numbers for unordered vertex pairs.
// req channel (valid/ready) carries one command; rsp channel (valid/ready)
// returns exactly one result per command. cfg channel (valid/ready, always
// ready) writes table_size_log2; write it only while the block is idle.
// Intern/find: the 64-bit hash runs on one shared 32x32 multiplier, three
// partial products per multiply, two multiplies. Each probe then reads a
// slot and compares it. Probing ends on a hit or an empty slot (which intern
// claims); a full table probes every slot in use.
// Read: one edge store read; an index past the count skips the read.
// Clear: a pass over all TABLE_SLOTS slots, one per cycle, then the result.
// One command is in flight at a time; req_ready is high only in idle, so the
// next command is taken once the previous result sits in the output register.
// Reset runs the same clearing pass with req_ready low; cfg writes are taken
// during it. If rsp_ready stays low, the result holds in the output register
// and the block stalls before loading the next one.
`include "edge_pair_hash_table_macros.svh"

module edge_pair_hash_table
    import epht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int MAX_EDGES   = MAX_EDGES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  epht_req_t         req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output epht_rsp_t         rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LOG2_W-1:0] cfg_data
);

    localparam int SLOT_AW    = $clog2(TABLE_SLOTS);
    localparam int SLOT_FLOOR = ((1 << SLOT_AW) == TABLE_SLOTS) ? SLOT_AW : SLOT_AW - 1;
    localparam int L_LIMIT    = (SLOT_FLOOR < TABLE_LOG2_CAP) ? SLOT_FLOOR : TABLE_LOG2_CAP;
    localparam logic [LOG2_W-1:0] L_LIMIT_V = LOG2_W'(L_LIMIT);
    localparam int EDGE_AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W      = $clog2(MAX_EDGES + 1);
    localparam int CMP_W      = (CNT_W > EDGE_ID_W) ? CNT_W : EDGE_ID_W;
    localparam logic [SLOT_AW-1:0] SWEEP_LAST = SLOT_AW'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0]   CNT_MAX    = CNT_W'(MAX_EDGES);

    typedef enum logic [6:0] {
        ST_SWEEP     = 7'b0000001,
        ST_IDLE      = 7'b0000010,
        ST_HASH      = 7'b0000100,
        ST_PROBE_RD  = 7'b0001000,
        ST_PROBE_CHK = 7'b0010000,
        ST_READ      = 7'b0100000,
        ST_EMIT      = 7'b1000000
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [EDGE_AW-1:0]  id;
        logic [VERTEX_W-1:0] low;
        logic [VERTEX_W-1:0] high;
    } slot_t;

    // control state
    state_t             state_reg,      state_next;
    logic [LOG2_W-1:0]  cfg_log2_reg;
    logic [CNT_W-1:0]   count_reg,      count_next;
    logic [SLOT_AW-1:0] sweep_reg,      sweep_next;
    logic               sweep_emit_reg, sweep_emit_next;
    logic               pass_reg,       pass_next;
    logic               rsp_valid_reg,  rsp_valid_next;

    // working payload
    cmd_t                  cmd_reg,       cmd_next;
    logic [VERTEX_W-1:0]   lo_reg,        lo_next;
    logic [VERTEX_W-1:0]   hi_reg,        hi_next;
    logic [SLOT_AW-1:0]    probe_idx_reg, probe_idx_next;
    logic [SLOT_AW-1:0]    probe_cnt_reg, probe_cnt_next;
    status_t               status_reg,    status_next;
    logic [EDGE_ID_W-1:0]  id_reg,        id_next;
    epht_rsp_t             rsp_reg,       rsp_next;
    slot_t                 slot_q_reg;

    // slot memory
    slot_t              slot_mem [TABLE_SLOTS];
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    slot_t              slot_wdata;
    logic               slot_re;

    // hash unit
    logic             mul_start;
    logic [KEY_W-1:0] mul_a;
    logic [KEY_W-1:0] mul_b;
    logic             mul_done;
    logic [KEY_W-1:0] mul_p;
    logic [KEY_W-1:0] hash_mix;

    // edge store
    logic                st_we;
    logic                st_re;
    logic [VERTEX_W-1:0] st_rd_low;
    logic [VERTEX_W-1:0] st_rd_high;

    // misc
    logic [LOG2_W-1:0]   l_clamp;
    logic [LOG2_W-1:0]   l_eff;
    logic [SLOT_AW-1:0]  mask;
    logic [VERTEX_W-1:0] pair_lo;
    logic [VERTEX_W-1:0] pair_hi;
    logic                idx_ok;
    logic                can_insert;
    logic                key_hit;

    epht_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    epht_edge_store #(
        .DEPTH (MAX_EDGES),
        .AW    (EDGE_AW)
    ) u_store (
        .clk     (clk),
        .we      (st_we),
        .waddr   (EDGE_AW'(count_reg)),
        .wr_low  (lo_reg),
        .wr_high (hi_reg),
        .re      (st_re),
        .raddr   (EDGE_AW'(req.edge_index)),
        .rd_low  (st_rd_low),
        .rd_high (st_rd_high)
    );

    // table size in use, clamped to the range and to the memory
    always_comb
    begin
        l_clamp = (cfg_log2_reg < TABLE_LOG2_MIN) ? TABLE_LOG2_MIN : cfg_log2_reg;
        l_eff   = (l_clamp > L_LIMIT_V) ? L_LIMIT_V : l_clamp;
        mask    = ~({SLOT_AW{1'b1}} << l_eff);
    end

    // ordered pair, read index check, probe decisions
    always_comb
    begin
        pair_lo    = (req.vertex_a < req.vertex_b) ? req.vertex_a : req.vertex_b;
        pair_hi    = (req.vertex_a < req.vertex_b) ? req.vertex_b : req.vertex_a;
        idx_ok     = CMP_W'(req.edge_index) < CMP_W'(count_reg);
        can_insert = (cmd_reg == CMD_INTERN) && (count_reg < CNT_MAX);
        key_hit    = (slot_q_reg.low == lo_reg) && (slot_q_reg.high == hi_reg);
        hash_mix   = xor_shift(mul_p);
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        sweep_next      = sweep_reg;
        sweep_emit_next = sweep_emit_reg;
        pass_next       = pass_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        cmd_next        = cmd_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        probe_idx_next  = probe_idx_reg;
        probe_cnt_next  = probe_cnt_reg;
        status_next     = status_reg;
        id_next         = id_reg;
        rsp_next        = rsp_reg;
        slot_we         = 1'b0;
        slot_waddr      = probe_idx_reg;
        slot_wdata      = '{valid: 1'b1, id: EDGE_AW'(count_reg), low: lo_reg, high: hi_reg};
        slot_re         = 1'b0;
        mul_start       = 1'b0;
        mul_a           = xor_shift({pair_lo, pair_hi});
        mul_b           = HASH_MUL1;
        st_we           = 1'b0;
        st_re           = 1'b0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                slot_we    = 1'b1;
                slot_waddr = sweep_reg;
                slot_wdata = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == SWEEP_LAST)
                begin
                    state_next      = sweep_emit_reg ? ST_EMIT : ST_IDLE;
                    sweep_emit_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next = req.command;
                    id_next  = '0;
                    lo_next  = '0;
                    hi_next  = '0;
                    unique case (req.command) inside
                        CMD_INTERN, CMD_FIND:
                        begin
                            lo_next     = pair_lo;
                            hi_next     = pair_hi;
                            mul_start   = 1'b1;
                            pass_next   = 1'b0;
                            status_next = (req.command == CMD_INTERN) ? STATUS_FULL
                                                                      : STATUS_MISS;
                            state_next  = ST_HASH;
                        end
                        CMD_READ:
                        begin
                            if (idx_ok)
                            begin
                                st_re       = 1'b1;
                                status_next = STATUS_FOUND;
                                id_next     = req.edge_index;
                                state_next  = ST_READ;
                            end
                            else
                            begin
                                status_next = STATUS_MISS;
                                state_next  = ST_EMIT;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next      = '0;
                            sweep_next      = '0;
                            sweep_emit_next = 1'b1;
                            status_next     = STATUS_NEW;
                            state_next      = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_HASH:
            begin
                if (mul_done)
                begin
                    if (!pass_reg)
                    begin
                        mul_start = 1'b1;
                        mul_a     = hash_mix;
                        mul_b     = HASH_MUL2;
                        pass_next = 1'b1;
                    end
                    else
                    begin
                        probe_idx_next = hash_mix[SLOT_AW-1:0] & mask;
                        probe_cnt_next = '0;
                        state_next     = ST_PROBE_RD;
                    end
                end
            end
            ST_PROBE_RD:
            begin
                slot_re    = 1'b1;
                state_next = ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                if (!slot_q_reg.valid)
                begin
                    // empty slot ends the probe, intern claims it unless the edge store is full
                    if (can_insert)
                    begin
                        slot_we     = 1'b1;
                        st_we       = 1'b1;
                        status_next = STATUS_NEW;
                        id_next     = EDGE_ID_W'(count_reg);
                        count_next  = count_reg + 1'b1;
                    end
                    state_next = ST_EMIT;
                end
                else if (key_hit)
                begin
                    status_next = STATUS_FOUND;
                    id_next     = EDGE_ID_W'(slot_q_reg.id);
                    state_next  = ST_EMIT;
                end
                else if (probe_cnt_reg == mask)
                begin
                    // every slot in use visited
                    state_next = ST_EMIT;
                end
                else
                begin
                    probe_idx_next = (probe_idx_reg + 1'b1) & mask;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    state_next     = ST_PROBE_RD;
                end
            end
            ST_READ:
            begin
                lo_next    = st_rd_low;
                hi_next    = st_rd_high;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status:     status_reg,
                                       edge_id:    id_reg,
                                       edge_low:   lo_reg,
                                       edge_high:  hi_reg,
                                       edge_total: EDGE_TOTAL_W'(count_reg)};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            cfg_log2_reg   <= TABLE_LOG2_RESET;
            count_reg      <= '0;
            sweep_reg      <= '0;
            sweep_emit_reg <= 1'b0;
            pass_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            sweep_reg      <= sweep_next;
            sweep_emit_reg <= sweep_emit_next;
            pass_reg       <= pass_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_log2_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        probe_idx_reg <= probe_idx_next;
        probe_cnt_reg <= probe_cnt_next;
        status_reg    <= status_next;
        id_reg        <= id_next;
        rsp_reg       <= rsp_next;
    end

    // slot memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re)
        begin
            slot_q_reg <= slot_mem[probe_idx_reg];
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    `EPHT_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_MAX, "edge count beyond store depth")
    `EPHT_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "second command taken while busy")
    `EPHT_ASSERT_NEXT(a_count_step, 1'b1, (count_reg == $past(count_reg)) || (count_reg == CNT_W'($past(count_reg) + 1'b1)) || (count_reg == '0), "edge count jumped")

endmodule

/* bench/edge_pair_hash_table_tb.sv */
`timescale 1ns / 1ps

module edge_pair_hash_table_tb;
    import epht_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 30;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    epht_req_t         req;
    logic              rsp_valid;
    logic              rsp_ready;
    epht_rsp_t         rsp;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [LOG2_W-1:0] cfg_data;

    int                send_idle_pct;
    int                recv_idle_pct;
    int unsigned       cmd_counts[4];

    // expected results of the edge table, predicted per accepted command
    class edge_table_scoreboard;
        bit                   slot_used[TABLE_SLOTS_DEF];
        logic [EDGE_ID_W-1:0] slot_edge[TABLE_SLOTS_DEF];
        logic [VERTEX_W-1:0]  low_store[MAX_EDGES_DEF];
        logic [VERTEX_W-1:0]  high_store[MAX_EDGES_DEF];
        int unsigned          edge_count;
        logic [LOG2_W-1:0]    size_log2;
        epht_rsp_t            expected_results[$];
        int unsigned          mismatches;
        int unsigned          checked;
        int unsigned          full_count;

        function new();
            edge_count = 0;
            size_log2  = TABLE_LOG2_RESET;
            mismatches = 0;
            checked    = 0;
            full_count = 0;
            foreach (slot_used[i])
            begin
                slot_used[i] = 1'b0;
            end
        endfunction

        // 64-bit finalizer, low half gives the home slot
        function logic [VERTEX_W-1:0] hash_pair(logic [VERTEX_W-1:0] lo,
                                                logic [VERTEX_W-1:0] hi);
            logic [KEY_W-1:0] k;
            k = {lo, hi};
            k = k ^ (k >> HASH_SHIFT);
            k = k * HASH_MUL1;
            k = k ^ (k >> HASH_SHIFT);
            k = k * HASH_MUL2;
            k = k ^ (k >> HASH_SHIFT);
            return k[VERTEX_W-1:0];
        endfunction

        // register saturates, then shrinks to fit the physical table
        function int unsigned active_slots();
            int unsigned l;
            l = size_log2;
            if (l < TABLE_LOG2_MIN)
                l = TABLE_LOG2_MIN;
            if (l > TABLE_LOG2_CAP)
                l = TABLE_LOG2_CAP;
            while (l > 0 && (1 << l) > TABLE_SLOTS_DEF)
                l--;
            return 1 << l;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        // work out the result of one accepted command
        function void note_command(epht_req_t item);
            epht_rsp_t            res;
            int unsigned          slots;
            int unsigned          home;
            int unsigned          n;
            logic [EDGE_ID_W-1:0] e;
            logic [VERTEX_W-1:0]  lo;
            logic [VERTEX_W-1:0]  hi;
            bit                   done;
            res = '0;
            res.status = STATUS_MISS;
            case (item.command)
                CMD_CLEAR:
                begin
                    foreach (slot_used[i])
                    begin
                        slot_used[i] = 1'b0;
                    end
                    edge_count = 0;
                    res.status = STATUS_NEW;
                end
                CMD_READ:
                begin
                    if (item.edge_index < edge_count)
                    begin
                        res.status    = STATUS_FOUND;
                        res.edge_id   = item.edge_index;
                        res.edge_low  = low_store[item.edge_index];
                        res.edge_high = high_store[item.edge_index];
                    end
                end
                default:
                begin
                    slots = active_slots();
                    lo = (item.vertex_a < item.vertex_b) ? item.vertex_a : item.vertex_b;
                    hi = (item.vertex_a < item.vertex_b) ? item.vertex_b : item.vertex_a;
                    res.edge_low  = lo;
                    res.edge_high = hi;
                    res.status = (item.command == CMD_INTERN) ? STATUS_FULL : STATUS_MISS;
                    home = hash_pair(lo, hi) & (slots - 1);
                    done = 1'b0;
                    // linear probe, at most one visit per slot in use
                    for (n = 0; n < slots && !done; n++)
                    begin
                        if (!slot_used[home])
                        begin
                            if (item.command == CMD_INTERN && edge_count < MAX_EDGES_DEF)
                            begin
                                low_store[edge_count]  = lo;
                                high_store[edge_count] = hi;
                                slot_edge[home]        = edge_count;
                                slot_used[home]        = 1'b1;
                                res.status             = STATUS_NEW;
                                res.edge_id            = edge_count;
                                edge_count++;
                            end
                            done = 1'b1;
                        end
                        else
                        begin
                            e = slot_edge[home];
                            if (e < edge_count && low_store[e] == lo && high_store[e] == hi)
                            begin
                                res.status  = STATUS_FOUND;
                                res.edge_id = e;
                                done        = 1'b1;
                            end
                        end
                        home = (home + 1) & (slots - 1);
                    end
                end
            endcase
            if (res.status == STATUS_FULL)
                full_count++;
            res.edge_total = edge_count;
            expected_results.push_back(res);
        endfunction

        // compare one result transfer with the oldest expectation
        task check_result(epht_rsp_t got);
            epht_rsp_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing expected", got));
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.status !== want.status)
                report_mismatch($sformatf("result %0d status %0d, want %0d",
                                          checked, got.status, want.status));
            if (got.edge_id !== want.edge_id)
                report_mismatch($sformatf("result %0d edge_id %0d, want %0d",
                                          checked, got.edge_id, want.edge_id));
            if (got.edge_low !== want.edge_low)
                report_mismatch($sformatf("result %0d edge_low %h, want %h",
                                          checked, got.edge_low, want.edge_low));
            if (got.edge_high !== want.edge_high)
                report_mismatch($sformatf("result %0d edge_high %h, want %h",
                                          checked, got.edge_high, want.edge_high));
            if (got.edge_total !== want.edge_total)
                report_mismatch($sformatf("result %0d edge_total %0d, want %0d",
                                          checked, got.edge_total, want.edge_total));
        endtask
    endclass

    edge_table_scoreboard sb;

    edge_pair_hash_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure, changed on the falling edge
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp);
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("[edge_pair_hash_table] ERROR");
        $finish;
    end

    function automatic epht_req_t command_item(cmd_t c, logic [VERTEX_W-1:0] a,
                                               logic [VERTEX_W-1:0] b,
                                               logic [EDGE_ID_W-1:0] idx);
        epht_req_t item;
        item.command    = c;
        item.vertex_a   = a;
        item.vertex_b   = b;
        item.edge_index = idx;
        return item;
    endfunction

    function automatic logic [VERTEX_W-1:0] corner_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 31);
            default: return ~$urandom_range(0, 31);
        endcase
    endfunction

    // one command transfer, with random sender gaps; called on a falling edge
    task automatic send_command(input epht_req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_command(item);
        cmd_counts[item.command]++;
        @(negedge clk);
    endtask

    // hold off the sender until every expected result has come back
    task automatic drain_results();
        req_valid <= 1'b0;
        @(negedge clk);
        while (sb.expected_results.size() != 0)
            @(negedge clk);
    endtask

    // table size register write; block must be idle
    task automatic write_table_size(input logic [LOG2_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.size_log2 = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // corners on a 16-slot table: orders, equal vertices, reads, full table
    task automatic run_directed();
        send_command(command_item(CMD_READ, '0, '0, '0));
        send_command(command_item(CMD_FIND, 32'd5, 32'd3, '0));
        send_command(command_item(CMD_INTERN, '1, '0, '1));
        send_command(command_item(CMD_INTERN, '0, '1, '0));
        send_command(command_item(CMD_FIND, '1, '0, '0));
        send_command(command_item(CMD_INTERN, 32'd7, 32'd7, '0));
        send_command(command_item(CMD_READ, $urandom, $urandom, '0));
        send_command(command_item(CMD_READ, '0, '0, '1));
        for (int i = 0; i < 14; i++)
            send_command(command_item(CMD_INTERN, 32'h100 + i, 32'h8000_0000 | i, '0));
        // every slot now taken
        send_command(command_item(CMD_INTERN, 32'h5A5A_5A5A, 32'hA5A5_A5A5, '0));
        send_command(command_item(CMD_FIND, 32'h5A5A_5A5A, 32'hA5A5_A5A5, '0));
        send_command(command_item(CMD_INTERN, 32'd7, 32'd7, '0));
        send_command(command_item(CMD_CLEAR, '0, '0, '0));
    endtask

    // random commands under one table size, table kept from before
    task automatic run_random_segment(input logic [LOG2_W-1:0] log2_value, input int count);
        epht_req_t           item;
        int                  pick;
        int unsigned         e;
        logic [VERTEX_W-1:0] swap;
        drain_results();
        write_table_size(log2_value);
        for (int k = 0; k < count; k++)
        begin
            item.vertex_a   = $urandom;
            item.vertex_b   = $urandom;
            item.edge_index = $urandom_range(0, 2047);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                item.command = CMD_INTERN;
            else if (pick < 70)
                item.command = CMD_FIND;
            else if (pick < 98)
                item.command = CMD_READ;
            else
                item.command = CMD_CLEAR;
            // pair: a stored edge, corner values, or fresh random
            pick = $urandom_range(0, 99);
            if (pick < 40 && sb.edge_count > 0)
            begin
                e = $urandom_range(0, sb.edge_count - 1);
                item.vertex_a = sb.low_store[e];
                item.vertex_b = sb.high_store[e];
                if ($urandom_range(0, 1))
                begin
                    swap          = item.vertex_a;
                    item.vertex_a = item.vertex_b;
                    item.vertex_b = swap;
                end
            end
            else if (pick < 65)
            begin
                item.vertex_a = corner_value();
                item.vertex_b = corner_value();
            end
            if (item.command == CMD_READ && sb.edge_count > 0 && $urandom_range(0, 3) != 0)
                item.edge_index = $urandom_range(0, sb.edge_count - 1);
            if ($urandom_range(0, 49) == 0)
                drain_results();
            send_command(item);
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (cmd_counts[i])
            cmd_counts[i] = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_table_size(TABLE_LOG2_MIN);
        run_directed();

        // sender mostly busy, receiver often stalled
        send_idle_pct = 13;
        recv_idle_pct = 54;
        run_random_segment(4'd12, 125);
        run_random_segment(4'd5, 125);

        // sender often idle, receiver mostly ready
        send_idle_pct = 54;
        recv_idle_pct = 13;
        run_random_segment(4'd0, 125);
        run_random_segment(4'd15, 125);

        // back-to-back traffic
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_segment(4'd8, 125);
        run_random_segment(4'd3, 125);

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.expected_results.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.expected_results.size()));

        $display("commands: %0d intern, %0d find, %0d read, %0d clear; %0d results checked",
                 cmd_counts[CMD_INTERN], cmd_counts[CMD_FIND], cmd_counts[CMD_READ],
                 cmd_counts[CMD_CLEAR], sb.checked);
        $display("table sizes 16 to 4096 slots, %0d full results, %0d mismatches",
                 sb.full_count, sb.mismatches);
        if (sb.mismatches == 0)
            $display("[edge_pair_hash_table] OK");
        else
            $display("[edge_pair_hash_table] ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/epht_pkg.sv
sv/epht_mul64.sv
sv/epht_edge_store.sv
sv/edge_pair_hash_table.sv
bench/edge_pair_hash_table_tb.sv
